/* rtl/spbb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_pkg - shared types and constants
// Field widths, register indexes, region codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spbb_pkg;

  // field widths
  localparam int SAMPLE_W   = 10;
  localparam int ANGLE_W    = 9;
  localparam int TOL_W      = 8;
  localparam int SPEED_W    = 8;
  localparam int DTYPE_W    = 2;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // iterative divider: two quotient bits per cycle
  localparam int DIV_W      = 20;
  localparam int DVS_W      = 10;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DIV_CNT_W  = 4;

  // direction driver types
  localparam logic [DTYPE_W-1:0] DRV_ONE_PIN = 2'd1;
  localparam logic [DTYPE_W-1:0] DRV_TWO_PIN = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ANGLE   = 3'd0,
    CFG_MAX_ANGLE   = 3'd1,
    CFG_MIN_POT     = 3'd2,
    CFG_MAX_POT     = 3'd3,
    CFG_TOLERANCE   = 3'd4,
    CFG_BASE_SPEED  = 3'd5,
    CFG_REVERSE     = 3'd6,
    CFG_DRIVER_TYPE = 3'd7
  } cfg_reg_e;

  typedef enum logic [REGION_W-1:0] {
    REG_STOP = 2'd0,
    REG_POS  = 2'd1,
    REG_NEG  = 2'd2,
    REG_HOLD = 2'd3
  } region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MEAN,
    ST_MULT,
    ST_MAPDIV,
    ST_MAPWAIT,
    ST_ANGLE,
    ST_DONE
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // capture input word, read ring slot
    logic update;     // refresh total, write ring
    logic mean_lat;   // register mean of the ring
    logic mult;       // form map product and span
    logic map_start;  // start map divide
    logic angle_lat;  // register clamped angle
    logic load_out;   // decide drive and load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic div_last;
  } dp_status_t;

endpackage

/* rtl/spbb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_ram - generic single-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spbb_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/spbb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_div - iterative unsigned divider
// Restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module spbb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [spbb_pkg::DIV_W-1:0] dividend_i,
  input  logic [spbb_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      last_o,
  output logic [spbb_pkg::DIV_W-1:0] quot_o
);

  import spbb_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W-1:0]     quo_q, quo_d;

  logic [DVS_W:0]   r1, r2, r1s, r2s;
  logic             ge1, ge2;
  logic             last;

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem_q, quo_q[DIV_W-1]};
    ge1 = (r1 >= {1'b0, dvs_q});
    r1s = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
    r2  = {r1s[DVS_W-1:0], quo_q[DIV_W-2]};
    ge2 = (r2 >= {1'b0, dvs_q});
    r2s = ge2 ? (r2 - {1'b0, dvs_q}) : r2;
  end

  assign last = busy_q && (cnt_q == DIV_CNT_W'(1));

  // run control and shift registers
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      rem_d  = r2s[DVS_W-1:0];
      quo_d  = {quo_q[DIV_W-3:0], ge1, ge2};
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign last_o = last;
  assign quot_o = quo_q;

  // a run is never restarted midway
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

/* rtl/spbb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_datapath - averaging, mapping and drive datapath
// Config registers, sample ring with running total, map multiply and
// divide, clamp, deadband decision and the output register.
// ----------------------------------------------------------------------------
module spbb_datapath #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config writes
  input  logic                          cfg_we_i,
  input  logic [spbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input word
  input  logic [spbb_pkg::SAMPLE_W-1:0] pot_sample_i,
  input  logic [spbb_pkg::ANGLE_W-1:0]  target_i,
  // control
  input  spbb_pkg::dp_cmd_t             cmd_i,
  output spbb_pkg::dp_status_t          status_o,
  // result word
  output logic [spbb_pkg::ANGLE_W-1:0]  angle_o,
  output logic                          dir_a_o,
  output logic                          dir_b_o,
  output logic [spbb_pkg::SPEED_W-1:0]  pwm_duty_o,
  output logic [spbb_pkg::REGION_W-1:0] drive_state_o
);

  import spbb_pkg::*;

  localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int TOT_W = SAMPLE_W + $clog2(AVG_DEPTH);
  localparam int unsigned TotalMax = ((2 ** SAMPLE_W) - 1) * AVG_DEPTH;
  // reciprocal for the mean: floor(x * MeanRecip / 2**MeanSh) = x / AVG_DEPTH
  localparam int REC_W  = TOT_W + 1;
  localparam int MUL_W  = TOT_W + REC_W;
  localparam int MeanSh = TOT_W + $clog2(AVG_DEPTH);
  localparam longint unsigned MeanRecip =
    ((64'd1 << MeanSh) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);

  // ---------------- config registers ----------------
  logic [ANGLE_W-1:0]  min_angle_q, max_angle_q;
  logic [SAMPLE_W-1:0] min_pot_q, max_pot_q;
  logic [TOL_W-1:0]    tolerance_q;
  logic [SPEED_W-1:0]  base_speed_q;
  logic                reverse_q;
  logic [DTYPE_W-1:0]  driver_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q   <= ANGLE_W'(0);
      max_angle_q   <= ANGLE_W'(180);
      min_pot_q     <= SAMPLE_W'(0);
      max_pot_q     <= SAMPLE_W'(1023);
      tolerance_q   <= TOL_W'(4);
      base_speed_q  <= SPEED_W'(255);
      reverse_q     <= 1'b0;
      driver_type_q <= DRV_ONE_PIN;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MIN_ANGLE:   min_angle_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_MAX_ANGLE:   max_angle_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_MIN_POT:     min_pot_q     <= cfg_data_i[SAMPLE_W-1:0];
        CFG_MAX_POT:     max_pot_q     <= cfg_data_i[SAMPLE_W-1:0];
        CFG_TOLERANCE:   tolerance_q   <= cfg_data_i[TOL_W-1:0];
        CFG_BASE_SPEED:  base_speed_q  <= cfg_data_i[SPEED_W-1:0];
        CFG_REVERSE:     reverse_q     <= cfg_data_i[0];
        CFG_DRIVER_TYPE: driver_type_q <= cfg_data_i[DTYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input capture ----------------
  logic [SAMPLE_W-1:0] sample_q;
  logic [ANGLE_W-1:0]  target_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= pot_sample_i;
      target_q <= target_i;
    end
  end

  // ---------------- sample ring and running total ----------------
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [AVG_DEPTH-1:0] ring_vld_q;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [SAMPLE_W-1:0]  ram_rdata, old_sample;

  spbb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (idx_q),
    .wdata_i (sample_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // slots never written read as zero
  always_comb begin
    old_sample = ring_vld_q[idx_q] ? ram_rdata : '0;
    total_d    = total_q - TOT_W'(old_sample) + TOT_W'(sample_q);
    idx_d      = (idx_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      ring_vld_q <= '0;
      total_q    <= '0;
    end else if (cmd_i.update) begin
      idx_q             <= idx_d;
      ring_vld_q[idx_q] <= 1'b1;
      total_q           <= total_d;
    end
  end

  // ---------------- mean by reciprocal multiply ----------------
  logic [MUL_W-1:0]    mean_prod;
  logic [SAMPLE_W-1:0] mean_q;

  assign mean_prod = MUL_W'(total_q) * MUL_W'(MeanRecip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_lat) begin
      mean_q <= mean_prod[MeanSh +: SAMPLE_W];
    end
  end

  // ---------------- map divider ----------------
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [DVS_W-1:0] div_divisor;
  logic             div_busy, div_last;

  logic signed [20:0] prod_q;   // (mean - min_pot) * (max_angle - min_angle)
  logic signed [10:0] span_q;   // max_pot - min_pot
  logic        [20:0] prod_mag;
  logic        [10:0] span_mag;

  assign prod_mag = prod_q[20] ? 21'(-prod_q) : 21'(prod_q);
  assign span_mag = span_q[10] ? 11'(-span_q) : 11'(span_q);

  // magnitudes in, sign restored after
  assign div_dividend = prod_mag[DIV_W-1:0];
  assign div_divisor  = span_mag[DVS_W-1:0];

  spbb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.map_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .last_o     (div_last),
    .quot_o     (div_quot)
  );

  assign status_o.div_busy = div_busy;
  assign status_o.div_last = div_last;

  // ---------------- map product ----------------
  logic signed [10:0] dx;
  logic signed [9:0]  dy;

  always_comb begin
    dx = $signed({1'b0, mean_q}) - $signed({1'b0, min_pot_q});
    dy = $signed({1'b0, max_angle_q}) - $signed({1'b0, min_angle_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      prod_q <= 21'(dx) * 21'(dy);
      span_q <= $signed({1'b0, max_pot_q}) - $signed({1'b0, min_pot_q});
    end
  end

  // ---------------- offset and clamp ----------------
  logic signed [21:0] q_signed, v, lo_s, hi_s;
  logic [ANGLE_W-1:0] angle_q, angle_d;

  always_comb begin
    q_signed = $signed({2'b00, div_quot});
    if (prod_q[20] ^ span_q[10]) begin
      q_signed = -q_signed;
    end
    lo_s = $signed({13'd0, min_angle_q});
    hi_s = $signed({13'd0, max_angle_q});
    // zero span maps everything to min_angle before the clamp
    v = (span_q == '0) ? lo_s : q_signed + lo_s;
    if (v < lo_s) begin
      angle_d = min_angle_q;
    end else if (v > hi_s) begin
      angle_d = max_angle_q;
    end else begin
      angle_d = v[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.angle_lat) begin
      angle_q <= angle_d;
    end
  end

  // ---------------- deadband decision ----------------
  logic signed [9:0] diff, half;
  region_e           region;
  logic              hold, drv_ok, drv_neg;
  logic [SPEED_W-1:0] drv_mag;

  always_comb begin
    diff = $signed({1'b0, angle_q}) - $signed({1'b0, target_q});
    half = $signed({3'b000, tolerance_q[TOL_W-1:1]});
    if (diff < half && diff > -half) begin
      region = REG_STOP;
    end else if (diff > half) begin
      region = REG_POS;
    end else if (diff < -half) begin
      region = REG_NEG;
    end else begin
      region = REG_HOLD;
    end
    hold    = (region == REG_HOLD);
    drv_ok  = (driver_type_q == DRV_ONE_PIN) || (driver_type_q == DRV_TWO_PIN);
    drv_mag = (region == REG_STOP) ? '0 : base_speed_q;
    // a zero magnitude never counts as negative
    drv_neg = (region != REG_STOP) && (base_speed_q != '0) &&
              ((region == REG_NEG) ^ reverse_q);
  end

  // ---------------- output register ----------------
  logic [ANGLE_W-1:0]  out_angle_q;
  logic                last_dir_a_q, last_dir_b_q;
  logic [SPEED_W-1:0]  last_pwm_q;
  region_e             out_region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dir_a_q <= 1'b0;
      last_dir_b_q <= 1'b0;
      last_pwm_q   <= '0;
    end else if (cmd_i.load_out && !hold && drv_ok) begin
      if (drv_neg) begin
        last_dir_a_q <= 1'b1;
        last_dir_b_q <= 1'b0;
        last_pwm_q   <= ~base_speed_q;  // 255 - speed
      end else begin
        last_dir_a_q <= 1'b0;
        last_dir_b_q <= (driver_type_q == DRV_TWO_PIN);
        last_pwm_q   <= drv_mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_angle_q  <= angle_q;
      out_region_q <= drv_ok ? region : REG_HOLD;
    end
  end

  assign angle_o       = out_angle_q;
  assign dir_a_o       = last_dir_a_q;
  assign dir_b_o       = last_dir_b_q;
  assign pwm_duty_o    = last_pwm_q;
  assign drive_state_o = out_region_q;

  // running total is the sum of at most AVG_DEPTH samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= TotalMax)
    else $error("running total out of range");

  // a written slot is marked valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> ring_vld_q[$past(idx_q)])
    else $error("ring slot not marked valid");

  // both direction lines never drive at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(last_dir_a_q && last_dir_b_q))
    else $error("both direction lines high");

endmodule

/* rtl/spbb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_ctrl - sequencing controller
// Steps one word through update, mean, map multiply and divide, clamp and
// decision; owns the input stall and output valid.
// ----------------------------------------------------------------------------
module spbb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spbb_pkg::dp_cmd_t    cmd_o,
  input  spbb_pkg::dp_status_t status_i
);

  import spbb_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  dp_cmd_t     cmd;

  // output register can take a word this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i)       state_d = ST_UPDATE;
      ST_UPDATE:                        state_d = ST_MEAN;
      ST_MEAN:                          state_d = ST_MULT;
      ST_MULT:                          state_d = ST_MAPDIV;
      ST_MAPDIV:                        state_d = ST_MAPWAIT;
      ST_MAPWAIT: if (status_i.div_last) state_d = ST_ANGLE;
      ST_ANGLE:                         state_d = ST_DONE;
      ST_DONE:    if (out_free)         state_d = ST_IDLE;
      default:                          state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd.accept = in_valid_i;
      end
      ST_UPDATE:  cmd.update    = 1'b1;
      ST_MEAN:    cmd.mean_lat  = 1'b1;
      ST_MULT:    cmd.mult      = 1'b1;
      ST_MAPDIV:  cmd.map_start = 1'b1;
      ST_ANGLE:   cmd.angle_lat = 1'b1;
      ST_DONE:    cmd.load_out  = out_free;
      default: ;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten");

  // wait state only while the divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAPWAIT) |-> status_i.div_busy)
    else $error("waiting on idle divider");

  // a loaded word is offered next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_q)
    else $error("loaded word not offered");

endmodule

/* rtl/servo_position_bang_bang_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_bang_bang_top - bang-bang servo position controller
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  pot_sample_i, target_i
//   out      output     out_valid_o/out_stall_i angle_o, dir_a_o, dir_b_o,
//                                              pwm_duty_o, drive_state_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A word's result is loaded into the output register once the word has
// passed update, mean, map multiply, map divide and clamp; the next word can
// be accepted in the following cycle, and not while a word is in flight.
// The map divider is two-bit-per-cycle; the mean is a reciprocal multiply.
// The next word is accepted once the result sits in the output register,
// even while it is still stalled. Reset is asynchronous; after it the ring
// reads as zero and no clearing pass runs. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module servo_position_bang_bang_top #(
  parameter int AVG_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  pot_sample_i,
  input  logic [8:0]  target_i,
  // result word
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  angle_o,
  output logic        dir_a_o,
  output logic        dir_b_o,
  output logic [7:0]  pwm_duty_o,
  output logic [1:0]  drive_state_o,
  // config writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  import spbb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  spbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  spbb_datapath #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pot_sample_i  (pot_sample_i),
    .target_i      (target_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .angle_o       (angle_o),
    .dir_a_o       (dir_a_o),
    .dir_b_o       (dir_b_o),
    .pwm_duty_o    (pwm_duty_o),
    .drive_state_o (drive_state_o)
  );

endmodule

/* tb/tb_servo_position_bang_bang_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_position_bang_bang_top - self-checking bench for the servo block
// Drives pot/target words through the valid/stall input channel and
// predicts each result word with a local moving-average, map, clamp and
// deadband model. Covers band edges, driver types, reverse, zero speed,
// degenerate and inverted ranges, and random configurations under
// several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_servo_position_bang_bang_top;
  import spbb_pkg::*;

  localparam int AVG_N      = 8;
  localparam int SETTLE_CYC = 40;    // settling wait after the drain, with margin
  localparam int WDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int RESET_CYC  = 12;
  localparam int ANGLE_TOP  = 360;
  localparam int POT_TOP    = 1023;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle;
    logic                dir_a;
    logic                dir_b;
    logic [7:0]          pwm;
    logic [REGION_W-1:0] region;
  } drive_word_t;

  // DUT connections
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [9:0]  pot_sample_i  = '0;
  logic [8:0]  target_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [8:0]  angle_o;
  logic        dir_a_o;
  logic        dir_b_o;
  logic [7:0]  pwm_duty_o;
  logic [1:0]  drive_state_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [9:0]  cfg_data_i    = '0;

  // local copy of the configuration, at reset values
  int                 cur_min_angle = 0;
  int                 cur_max_angle = 180;
  int                 cur_min_pot   = 0;
  int                 cur_max_pot   = 1023;
  int                 cur_tolerance = 4;
  int                 cur_speed     = 255;
  logic               cur_reverse   = 1'b0;
  logic [DTYPE_W-1:0] cur_dtype     = DRV_ONE_PIN;

  // local copy of the averaging ring and held outputs
  int         ring_hist [AVG_N] = '{default: 0};
  int         ring_sum   = 0;
  int         ring_pos   = 0;
  logic       held_dir_a = 1'b0;
  logic       held_dir_b = 1'b0;
  logic [7:0] held_pwm   = '0;

  drive_word_t pending_drive[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  servo_position_bang_bang_top #(
    .AVG_DEPTH(AVG_N)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .pot_sample_i,
    .target_i,
    .out_valid_o,
    .out_stall_i,
    .angle_o,
    .dir_a_o,
    .dir_b_o,
    .pwm_duty_o,
    .drive_state_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // linear map of a mean reading onto the angle range, then clamp
  function automatic int map_to_angle(input int mean);
    int v;
    if (cur_max_pot == cur_min_pot) begin
      v = cur_min_angle;
    end else begin
      v = (mean - cur_min_pot) * (cur_max_angle - cur_min_angle)
          / (cur_max_pot - cur_min_pot) + cur_min_angle;
    end
    if (v < cur_min_angle) begin
      v = cur_min_angle;
    end else if (v > cur_max_angle) begin
      v = cur_max_angle;
    end
    return v;
  endfunction

  // angle the block will report once this sample is in the ring
  function automatic int next_angle(input int pot);
    return map_to_angle((ring_sum - ring_hist[ring_pos] + pot) / AVG_N);
  endfunction

  // advance the ring and work out the result word for one input word
  function automatic drive_word_t compute_drive(input int pot, input int tgt);
    int          ang;
    int          diff;
    int          half;
    int          drv;
    logic        hold;
    drive_word_t w;
    ang = next_angle(pot);
    ring_sum = ring_sum - ring_hist[ring_pos] + pot;
    ring_hist[ring_pos] = pot;
    ring_pos = (ring_pos == AVG_N - 1) ? 0 : ring_pos + 1;

    diff = ang - tgt;
    half = cur_tolerance / 2;
    drv  = 0;
    hold = 1'b0;
    if (diff < half && diff > -half) begin
      w.region = REG_STOP;
    end else if (diff > half) begin
      w.region = REG_POS;
      drv = cur_speed;
    end else if (diff < -half) begin
      w.region = REG_NEG;
      drv = -cur_speed;
    end else begin
      // exactly on a band edge
      w.region = REG_HOLD;
      hold = 1'b1;
    end

    if (!hold) begin
      if (cur_reverse) drv = -drv;
      if (cur_dtype == DRV_ONE_PIN || cur_dtype == DRV_TWO_PIN) begin
        if (drv >= 0) begin
          held_dir_a = 1'b0;
          held_dir_b = (cur_dtype == DRV_TWO_PIN);
          held_pwm   = 8'(drv);
        end else begin
          held_dir_a = 1'b1;
          held_dir_b = 1'b0;
          held_pwm   = 8'(255 + drv);
        end
      end else begin
        // unknown driver type: nothing applied, outputs held
        w.region = REG_HOLD;
      end
    end

    w.angle = ANGLE_W'(ang);
    w.dir_a = held_dir_a;
    w.dir_b = held_dir_b;
    w.pwm   = held_pwm;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    // keep the log short if the block is badly off
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
    end
  endtask

  // compare every accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    drive_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected result word", angle_o, 0);
      end else begin
        want = pending_drive.pop_front();
        if (angle_o !== want.angle) report_mismatch("angle", angle_o, want.angle);
        if (dir_a_o !== want.dir_a) report_mismatch("dir_a", dir_a_o, want.dir_a);
        if (dir_b_o !== want.dir_b) report_mismatch("dir_b", dir_b_o, want.dir_b);
        if (pwm_duty_o !== want.pwm) report_mismatch("pwm_duty", pwm_duty_o, want.pwm);
        if (drive_state_o !== want.region) begin
          report_mismatch("drive_state", drive_state_o, want.region);
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && (int'($urandom_range(99)) < recv_stall_pct);
  end

  // watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb_servo_position_bang_bang_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  task automatic set_idling(input int idle_phase);
    case (idle_phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // hold off input until every predicted word has come back
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic send_word(input int pot, input int tgt);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pot_sample_i <= 10'(pot);
    target_i     <= 9'(tgt);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_drive.push_back(compute_drive(pot, tgt));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 10'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MIN_ANGLE:   cur_min_angle = value & 'h1FF;
      CFG_MAX_ANGLE:   cur_max_angle = value & 'h1FF;
      CFG_MIN_POT:     cur_min_pot   = value & 'h3FF;
      CFG_MAX_POT:     cur_max_pot   = value & 'h3FF;
      CFG_TOLERANCE:   cur_tolerance = value & 'hFF;
      CFG_BASE_SPEED:  cur_speed     = value & 'hFF;
      CFG_REVERSE:     cur_reverse   = value[0];
      CFG_DRIVER_TYPE: cur_dtype     = value[DTYPE_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain, then write the whole register set
  task automatic set_config(input int min_a, input int max_a, input int min_p,
                            input int max_p, input int tol, input int spd,
                            input int rev, input int dtype);
    wait_quiet();
    write_reg(CFG_MIN_ANGLE, min_a);
    write_reg(CFG_MAX_ANGLE, max_a);
    write_reg(CFG_MIN_POT, min_p);
    write_reg(CFG_MAX_POT, max_p);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_BASE_SPEED, spd);
    write_reg(CFG_REVERSE, rev);
    write_reg(CFG_DRIVER_TYPE, dtype);
  endtask

  // pot drifts around a level so the mean settles, with jumps and extremes;
  // half of the targets sit in the band or just past its edges
  task automatic send_random(input int count);
    int pot;
    int tgt;
    int half;
    pot = $urandom_range(POT_TOP);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(7))
        0:       pot = $urandom_range(POT_TOP);
        1:       pot = $urandom_range(1) ? POT_TOP : 0;
        default: pot = pot + int'($urandom_range(16)) - 8;
      endcase
      if (pot < 0) pot = 0;
      if (pot > POT_TOP) pot = POT_TOP;

      half = cur_tolerance / 2;
      if ($urandom_range(1)) begin
        tgt = next_angle(pot) + int'($urandom_range(2 * half + 2)) - (half + 1);
      end else begin
        tgt = $urandom_range(ANGLE_TOP);
      end
      if (tgt < 0) tgt = 0;
      if (tgt > ANGLE_TOP) tgt = ANGLE_TOP;

      // now and then let the pipeline run dry
      if ($urandom_range(63) == 0) wait_quiet();
      send_word(pot, tgt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset configuration: field extremes, both drive signs, band edges
  task automatic test_directed();
    int a;
    int half;
    set_idling(0);
    send_word(0, ANGLE_TOP);
    repeat (AVG_N) send_word(POT_TOP, 0);
    a    = next_angle(POT_TOP);
    half = cur_tolerance / 2;
    send_word(POT_TOP, a);              // centered in the band
    send_word(POT_TOP, a + half);       // lower band edge, hold
    send_word(POT_TOP, a - half);       // upper band edge, hold
    send_word(POT_TOP, a + 1);          // inside the band
    send_word(POT_TOP, a + half + 1);   // just below the band
    send_word(POT_TOP, a - half - 1);   // just above the band
    send_word(511, 255);
    send_word(512, 256);
  endtask

  // deadband widths, including zero and one where zero error holds
  task automatic test_band_edges();
    int tol_set [4] = '{0, 1, 2, 255};
    for (int k = 0; k < 4; k++) begin
      set_config(0, ANGLE_TOP, 0, POT_TOP, tol_set[k], 200, 0, DRV_TWO_PIN);
      set_idling(k);
      send_random(35);
    end
  endtask

  // reverse, every driver type code, zero and small speed
  task automatic test_drive_modes();
    set_config(0, 180, 0, POT_TOP, 4, 255, 1, DRV_ONE_PIN);
    set_idling(1);
    send_random(30);
    set_config(0, 180, 0, POT_TOP, 6, 100, 1, DRV_TWO_PIN);
    set_idling(2);
    send_random(30);
    set_config(0, 180, 0, POT_TOP, 4, 150, 0, 0);
    set_idling(3);
    send_random(30);
    set_config(0, 180, 0, POT_TOP, 4, 150, 1, 3);
    set_idling(0);
    send_random(30);
    set_config(0, 180, 0, POT_TOP, 4, 0, 0, DRV_TWO_PIN);
    set_idling(2);
    send_random(30);
    set_config(0, ANGLE_TOP, 0, POT_TOP, 3, 1, 0, DRV_ONE_PIN);
    set_idling(1);
    send_random(30);
  endtask

  // zero pot span, inverted angle and pot ranges, full and narrow ranges
  task automatic test_mapping();
    set_config(10, 300, 500, 500, 4, 255, 0, DRV_ONE_PIN);
    set_idling(3);
    send_random(30);
    set_config(300, 20, 0, POT_TOP, 8, 200, 0, DRV_TWO_PIN);
    set_idling(0);
    send_random(30);
    set_config(0, ANGLE_TOP, POT_TOP, 0, 4, 128, 1, DRV_ONE_PIN);
    set_idling(1);
    send_random(30);
    set_config(ANGLE_TOP, ANGLE_TOP, 400, 600, 2, 255, 0, DRV_TWO_PIN);
    set_idling(2);
    send_random(30);
    set_config(0, ANGLE_TOP, 0, POT_TOP, 4, 255, 0, DRV_ONE_PIN);
    set_idling(0);
    send_random(30);
  endtask

  // random register sets under every idling mix
  task automatic test_random_mix();
    int a0;
    int a1;
    int p0;
    int p1;
    int tol;
    int dtype;
    int tmp;
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 3; k++) begin
        a0 = $urandom_range(ANGLE_TOP);
        a1 = $urandom_range(ANGLE_TOP);
        p0 = $urandom_range(POT_TOP);
        p1 = $urandom_range(POT_TOP);
        // mostly ascending ranges, sometimes inverted
        if ($urandom_range(3) != 0 && a0 > a1) begin
          tmp = a0; a0 = a1; a1 = tmp;
        end
        if ($urandom_range(3) != 0 && p0 > p1) begin
          tmp = p0; p0 = p1; p1 = tmp;
        end
        tol = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12);
        if ($urandom_range(7) == 0) begin
          dtype = $urandom_range(1) ? 3 : 0;
        end else begin
          dtype = $urandom_range(1) ? DRV_TWO_PIN : DRV_ONE_PIN;
        end
        set_config(a0, a1, p0, p1, tol, $urandom_range(255), $urandom_range(1), dtype);
        set_idling(ph);
        send_random(50);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_band_edges();
    test_drive_modes();
    test_mapping();
    test_random_mix();

    set_idling(0);
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("tb_servo_position_bang_bang_top: done, clean");
    end else begin
      $display("tb_servo_position_bang_bang_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/spbb_pkg.sv
rtl/spbb_ram.sv
rtl/spbb_div.sv
rtl/spbb_datapath.sv
rtl/spbb_ctrl.sv
rtl/servo_position_bang_bang_top.sv
tb/tb_servo_position_bang_bang_top.sv
